### src/btbp_pkg.sv
package btbp_pkg;

   localparam int unsigned PC_W = 32;

   localparam logic [PC_W-1:0] INSN_BYTES = 32'd4;

   // 2-bit prediction state: the two low codes predict taken
   localparam logic [1:0] ST_STRONG_T  = 2'b00;
   localparam logic [1:0] ST_WEAK_T    = 2'b01;
   localparam logic [1:0] ST_WEAK_NT   = 2'b10;
   localparam logic [1:0] ST_STRONG_NT = 2'b11;

   localparam logic SCHEME_PLAIN = 1'b0;
   localparam logic SCHEME_JUMP  = 1'b1;

   typedef struct packed {
      logic [PC_W-1:0] cur;
      logic [PC_W-1:0] nxt;
   } item_type;

   typedef struct packed {
      logic [PC_W-1:0] addr;
      logic [PC_W-1:0] target;
      logic [1:0]      state;
   } entry_type;

   function automatic logic [1:0] step_state(logic [1:0] s, logic went, logic scheme);
      logic [1:0] r;
      if (went) begin
         r = (s == ST_STRONG_T) ? s : s - 2'd1;
      end else if (scheme == SCHEME_JUMP && s == ST_WEAK_T) begin
         r = ST_STRONG_NT;
      end else begin
         r = (s == ST_STRONG_NT) ? s : s + 2'd1;
      end
      return r;
   endfunction

endpackage

### src/btbp_index.sv
module btbp_index #(
   parameter int unsigned ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  btbp_pkg::item_type         in_item,
   output logic                       out_valid,
   output btbp_pkg::item_type         out_item,
   output logic [$clog2(ENTRIES)-1:0] out_idx
);
   import btbp_pkg::*;

   localparam int unsigned IDXW = $clog2(ENTRIES);
   localparam int unsigned XW   = PC_W - 2;
   localparam bit          POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         assign out_valid = in_valid;
         assign out_item  = in_item;
         assign out_idx   = in_item.cur[IDXW+1:2];
      end else begin : g_residue
         // word address mod ENTRIES: reciprocal multiply, back-multiply,
         // then one compare-and-subtract since the estimate is at most one low
         localparam int unsigned MW = XW + 1 - IDXW;
         localparam int unsigned PW = XW + MW;
         localparam longint unsigned RECIP_INT = (64'd1 << XW) / ENTRIES;
         localparam logic [MW-1:0] RECIP = MW'(RECIP_INT);
         localparam logic [XW-1:0] DIV   = XW'(ENTRIES);

         logic           a_valid_ff, b_valid_ff;
         item_type       a_item_ff, b_item_ff;
         logic [PW-1:0]  a_prod_ff, a_prod_in;
         logic [XW-1:0]  b_qe_ff, b_qe_in;
         logic [MW-1:0]  quot;
         logic [XW-1:0]  rem;

         assign a_prod_in = PW'(in_item.cur[PC_W-1:2]) * PW'(RECIP);
         assign quot      = a_prod_ff[PW-1:XW];
         assign b_qe_in   = XW'(quot) * DIV;
         assign rem       = b_item_ff.cur[PC_W-1:2] - b_qe_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               a_valid_ff <= 1'b0;
               b_valid_ff <= 1'b0;
            end else if (adv) begin
               a_valid_ff <= in_valid;
               b_valid_ff <= a_valid_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               a_item_ff <= in_item;
               a_prod_ff <= a_prod_in;
               b_item_ff <= a_item_ff;
               b_qe_ff   <= b_qe_in;
            end
         end

         assign out_valid = b_valid_ff;
         assign out_item  = b_item_ff;
         assign out_idx   = (rem >= DIV) ? IDXW'(rem - DIV) : IDXW'(rem);
      end
   endgenerate

endmodule

### src/branch_target_buffer_predictor_core.sv
// Direct-mapped branch target buffer with a 2-bit prediction state per entry.
// One address pair is taken per clock and one result beat comes back for each;
// the pipeline stalls as a whole only while a result beat waits on rsp_ready.
// With ENTRIES a power of two the index comes straight from the address bits;
// otherwise the index is reduced modulo ENTRIES in two extra pipeline stages
// ahead of the compute stage and the result register. The entry store
// is a single memory with one registered read and one write per cycle; the
// entry written back by one item is forwarded to the item right behind it.
// After reset the block sweeps the store to zero, one entry per cycle, and
// holds req_ready low until the sweep is done. csr_counter_scheme selects the
// state update: 0 plain saturating steps, 1 not-taken from weak-taken jumps
// straight to strong-not-taken. Write it only while no beat is in flight.
module branch_target_buffer_predictor_core #(
   parameter int unsigned ENTRIES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [btbp_pkg::PC_W-1:0]   req_current_pc,
   input  logic [btbp_pkg::PC_W-1:0]   req_next_pc,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_lookup_hit,
   output logic                        rsp_predicted_taken,
   output logic                        rsp_actually_taken,
   output logic                        rsp_prediction_right,
   output logic                        rsp_target_wrong,
   output logic                        rsp_entry_allocated,
   output logic                        rsp_collision,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_counter_scheme
);
   import btbp_pkg::*;

   localparam int unsigned IDXW = $clog2(ENTRIES);

   entry_type btb_mem [ENTRIES];

   logic            adv;
   logic            scheme_ff;
   logic            clr_active_ff;
   logic [IDXW-1:0] clr_idx_ff;

   item_type        req_item;
   logic            ix_valid;
   item_type        ix_item;
   logic [IDXW-1:0] ix_idx;

   logic            s_valid_ff;
   item_type        s_item_ff;
   logic [IDXW-1:0] s_idx_ff;
   entry_type       rd_entry_ff;
   logic            byp_hit_ff;
   entry_type       byp_entry_ff;

   entry_type       ent;
   entry_type       entry_in;
   logic [PC_W-1:0] seq_pc;
   logic            hit_in, pred_in, taken_in, right_in, twrong_in, alloc_in, coll_in;
   logic            item_we;

   logic            mem_we;
   logic [IDXW-1:0] mem_waddr;
   entry_type       mem_wdata;

   logic rsp_valid_ff, hit_ff, pred_ff, taken_ff, right_ff, twrong_ff, alloc_ff, coll_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clr_active_ff;
   assign csr_ready = 1'b1;
   assign req_item  = '{cur: req_current_pc, nxt: req_next_pc};

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= SCHEME_PLAIN;
      end else if (csr_valid && csr_ready) begin
         scheme_ff <= csr_counter_scheme;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDXW'(ENTRIES - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   btbp_index #(
      .ENTRIES (ENTRIES)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid && req_ready),
      .in_item   (req_item),
      .out_valid (ix_valid),
      .out_item  (ix_item),
      .out_idx   (ix_idx)
   );

   // lookup and update of the entry read for the item in the compute stage
   always_comb begin
      ent       = byp_hit_ff ? byp_entry_ff : rd_entry_ff;
      seq_pc    = s_item_ff.cur + INSN_BYTES;
      taken_in  = s_item_ff.nxt != seq_pc;
      hit_in    = (ent.target != '0) && (ent.addr == s_item_ff.cur);
      pred_in   = hit_in && !ent.state[1];
      right_in  = 1'b0;
      twrong_in = 1'b0;
      alloc_in  = 1'b0;
      coll_in   = 1'b0;
      entry_in  = ent;
      if (hit_in) begin
         if (pred_in) begin
            if (ent.target == s_item_ff.nxt) begin
               entry_in.state = step_state(ent.state, 1'b1, scheme_ff);
               right_in       = 1'b1;
            end else if (taken_in) begin
               // wrong target: not-taken step, then taken step, new target
               twrong_in       = 1'b1;
               entry_in.state  = step_state(step_state(ent.state, 1'b0, scheme_ff),
                                            1'b1, scheme_ff);
               entry_in.target = s_item_ff.nxt;
            end else begin
               entry_in.state = step_state(ent.state, 1'b0, scheme_ff);
            end
         end else if (!taken_in) begin
            entry_in.state = step_state(ent.state, 1'b0, scheme_ff);
            right_in       = 1'b1;
         end else begin
            entry_in.state  = step_state(ent.state, 1'b1, scheme_ff);
            entry_in.target = s_item_ff.nxt;
         end
      end else if (taken_in) begin
         alloc_in = 1'b1;
         coll_in  = ent.addr != '0;
         entry_in = '{addr: s_item_ff.cur, target: s_item_ff.nxt, state: ST_STRONG_T};
      end
   end

   assign item_we   = s_valid_ff && adv && (hit_in || taken_in);
   assign mem_we    = clr_active_ff || item_we;
   assign mem_waddr = clr_active_ff ? clr_idx_ff : s_idx_ff;
   assign mem_wdata = clr_active_ff ? entry_type'('0) : entry_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         btb_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_entry_ff  <= btb_mem[ix_idx];
         s_item_ff    <= ix_item;
         s_idx_ff     <= ix_idx;
         // the read above sees the old entry if it is being written this edge
         byp_hit_ff   <= item_we && (s_idx_ff == ix_idx);
         byp_entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff   <= ix_valid;
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff    <= hit_in;
         pred_ff   <= pred_in;
         taken_ff  <= taken_in;
         right_ff  <= right_in;
         twrong_ff <= twrong_in;
         alloc_ff  <= alloc_in;
         coll_ff   <= coll_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_lookup_hit       = hit_ff;
   assign rsp_predicted_taken  = pred_ff;
   assign rsp_actually_taken   = taken_ff;
   assign rsp_prediction_right = right_ff;
   assign rsp_target_wrong     = twrong_ff;
   assign rsp_entry_allocated  = alloc_ff;
   assign rsp_collision        = coll_ff;

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s_valid_ff && !rsp_valid_ff)
      else $error("item in flight during store clear");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && !adv |=> s_valid_ff && $stable(s_idx_ff))
      else $error("compute stage item lost while stalled");

   a_alloc_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_allocated || rsp_collision) |->
         !rsp_lookup_hit && rsp_actually_taken && rsp_entry_allocated)
      else $error("allocation flags inconsistent with lookup");

   a_right_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_prediction_right || rsp_target_wrong || rsp_predicted_taken)
         |-> rsp_lookup_hit)
      else $error("prediction flags without a hit");

endmodule

### test/tb_top.sv
module tb_top;
   import btbp_pkg::*;

   localparam int unsigned BTB_DEPTH   = 1024;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned PHASE_ITEMS = 350;
   localparam int unsigned CALM_TAIL   = 150;
   localparam int unsigned POOL_SIZE   = 32;
   localparam int unsigned ROW_COUNT   = 24;
   localparam int unsigned REPORT_MAX  = 10;

   typedef struct packed {
      logic hit;
      logic pred_taken;
      logic taken;
      logic right;
      logic target_wrong;
      logic alloc;
      logic collision;
   } outcome_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            scheme;
      logic [PC_W-1:0] cur;
      logic [PC_W-1:0] nxt;
      logic            typed;
      outcome_type     want;
   } stim_row_type;

   // typed outcomes read {hit, pred, taken, right, twrong, alloc, coll}
   stim_row_type directed_rows [ROW_COUNT] = '{
      '{ROW_CSR,  SCHEME_PLAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_0000, 32'h0000_0004, 1'b1, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_2000, 1'b1, 7'b0010010},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_2000, 1'b1, 7'b1111000},
      // predicted taken, falls through
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_1004, 1'b0, 7'b0000000},
      // predicted taken, taken elsewhere
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_3000, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_1004, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_1004, 1'b0, 7'b0000000},
      // predicted not taken, taken
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_1000, 32'h0000_5000, 1'b0, 7'b0000000},
      // same slot, other tag, zero target written
      '{ROW_ITEM, SCHEME_PLAIN, 32'h2000_1000, 32'h0000_0000, 1'b1, 7'b0010011},
      // tag matches but target zero: still a miss
      '{ROW_ITEM, SCHEME_PLAIN, 32'h2000_1000, 32'h0000_1234, 1'b1, 7'b0010011},
      // sequential address wraps past the top
      '{ROW_ITEM, SCHEME_PLAIN, 32'hFFFF_FFFC, 32'h0000_0000, 1'b1, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 7'b0010010},
      '{ROW_ITEM, SCHEME_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_PLAIN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 7'b0000000},
      '{ROW_CSR,  SCHEME_JUMP,  32'h0000_0000, 32'h0000_0000, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'h0000_0804, 32'h0ABC_0000, 1'b1, 7'b0010010},
      // weak taken then straight to strong not taken
      '{ROW_ITEM, SCHEME_JUMP,  32'h0000_0804, 32'h0000_0808, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'h0000_0804, 32'h0000_0808, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'h0000_0804, 32'h0000_0808, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'h0000_0804, 32'h0ABC_0000, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'hAAAA_5554, 32'h5555_5555, 1'b0, 7'b0000000},
      '{ROW_ITEM, SCHEME_JUMP,  32'h5555_AAA8, 32'hAAAA_AAAA, 1'b0, 7'b0000000}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [PC_W-1:0] req_current_pc;
   logic [PC_W-1:0] req_next_pc;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic            rsp_lookup_hit;
   logic            rsp_predicted_taken;
   logic            rsp_actually_taken;
   logic            rsp_prediction_right;
   logic            rsp_target_wrong;
   logic            rsp_entry_allocated;
   logic            rsp_collision;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_counter_scheme;

   logic            throttle_on = 1'b1;
   logic            rsp_holding = 1'b0;
   int unsigned     hold_cycles = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     fail_count = 0;

   entry_type       shadow_table [BTB_DEPTH];
   logic            shadow_scheme;
   outcome_type     outcome_q [$];

   logic [PC_W-1:0] branch_pool [POOL_SIZE];
   logic [PC_W-1:0] target_pool [POOL_SIZE][2];

   branch_target_buffer_predictor_core #(
      .ENTRIES(BTB_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_current_pc      (req_current_pc),
      .req_next_pc         (req_next_pc),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_lookup_hit      (rsp_lookup_hit),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_actually_taken  (rsp_actually_taken),
      .rsp_prediction_right(rsp_prediction_right),
      .rsp_target_wrong    (rsp_target_wrong),
      .rsp_entry_allocated (rsp_entry_allocated),
      .rsp_collision       (rsp_collision),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_counter_scheme  (csr_counter_scheme)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [1:0] counter_step(logic [1:0] s, logic went);
      if (went) begin
         return (s == ST_STRONG_T) ? ST_STRONG_T : s - 2'd1;
      end
      if (shadow_scheme == SCHEME_JUMP && s == ST_WEAK_T) begin
         return ST_STRONG_NT;
      end
      return (s == ST_STRONG_NT) ? ST_STRONG_NT : s + 2'd1;
   endfunction

   // looks up and updates the shadow table for one address pair
   function automatic outcome_type resolve_branch(logic [PC_W-1:0] cur,
                                                  logic [PC_W-1:0] nxt);
      int unsigned slot;
      entry_type   e;
      outcome_type o;
      slot = (cur >> 2) % BTB_DEPTH;
      e = shadow_table[slot];
      o = '0;
      o.taken = (nxt != cur + INSN_BYTES);
      o.hit = (e.target != '0) && (e.addr == cur);
      if (o.hit) begin
         o.pred_taken = (e.state == ST_STRONG_T) || (e.state == ST_WEAK_T);
         if (o.pred_taken && e.target == nxt) begin
            e.state = counter_step(e.state, 1'b1);
            o.right = 1'b1;
         end else if (o.pred_taken) begin
            e.state = counter_step(e.state, 1'b0);
            if (o.taken) begin
               // wrong target: not-taken step, then taken step
               o.target_wrong = 1'b1;
               e.state = counter_step(e.state, 1'b1);
               e.target = nxt;
            end
         end else if (!o.taken) begin
            e.state = counter_step(e.state, 1'b0);
            o.right = 1'b1;
         end else begin
            e.state = counter_step(e.state, 1'b1);
            e.target = nxt;
         end
      end else if (o.taken) begin
         o.alloc = 1'b1;
         o.collision = (e.addr != '0);
         e.addr = cur;
         e.target = nxt;
         e.state = ST_STRONG_T;
      end
      shadow_table[slot] = e;
      return o;
   endfunction

   function automatic void note_failure(string what, outcome_type want, outcome_type seen);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%0t %s: want %b got %b (hit pred taken right twrong alloc coll)",
                  $realtime, what, want, seen);
      end
   endfunction

   task automatic send_pair(logic [PC_W-1:0] cur, logic [PC_W-1:0] nxt, logic typed,
                            outcome_type want);
      outcome_type o;
      req_valid      <= 1'b1;
      req_current_pc <= cur;
      req_next_pc    <= nxt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      o = resolve_branch(cur, nxt);
      outcome_q.push_back(typed ? want : o);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // only with the pipeline drained
   task automatic write_scheme(logic scheme);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_counter_scheme <= scheme;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      shadow_scheme = scheme;
   endtask

   task automatic send_random_pair();
      logic [PC_W-1:0] cur;
      logic [PC_W-1:0] nxt;
      int unsigned     b;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         cur = $urandom;
         nxt = (pick < 3) ? cur + INSN_BYTES : $urandom;
      end else begin
         b = $urandom_range(0, POOL_SIZE - 1);
         cur = branch_pool[b];
         pick = $urandom_range(0, 99);
         if (pick < 35) nxt = cur + INSN_BYTES;
         else if (pick < 80) nxt = target_pool[b][$urandom_range(0, 1)];
         else if (pick < 96) nxt = $urandom;
         else nxt = '0;
      end
      if (throttle_on && $urandom_range(0, 7) == 0) begin
         pause_sender($urandom_range(1, 17));
      end
      send_pair(cur, nxt, 1'b0, '0);
   endtask

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (hold_cycles == 0) begin
         rsp_holding = throttle_on && ($urandom_range(0, 3) == 0);
         hold_cycles = rsp_holding ? $urandom_range(1, 17) : $urandom_range(1, 40);
      end
      hold_cycles--;
      rsp_ready <= !(rsp_holding && throttle_on);
   end

   always @(posedge clock) begin : check_beat
      outcome_type seen;
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_lookup_hit, rsp_predicted_taken, rsp_actually_taken,
                 rsp_prediction_right, rsp_target_wrong, rsp_entry_allocated,
                 rsp_collision};
         if (outcome_q.size() == 0) begin
            note_failure("unexpected result beat", '0, seen);
         end else begin
            want = outcome_q.pop_front();
            if (seen !== want) note_failure("result mismatch", want, seen);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned i;
      int unsigned n;
      int unsigned phase;
      int unsigned hi;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_current_pc     = '0;
      req_next_pc        = '0;
      csr_valid          = 1'b0;
      csr_counter_scheme = SCHEME_PLAIN;
      shadow_scheme      = SCHEME_PLAIN;
      for (i = 0; i < BTB_DEPTH; i++) shadow_table[i] = '0;

      // second half of the pool aliases the first half's slots (entries 0 and 1 are replaced below)
      for (i = 0; i < POOL_SIZE; i++) begin
         if (i < POOL_SIZE / 2) begin
            branch_pool[i] = $urandom;
         end else begin
            hi = $urandom_range(1, 32'h000F_FFFF);
            branch_pool[i] = branch_pool[i - POOL_SIZE / 2] ^ (hi << 12);
         end
         target_pool[i][0] = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
         target_pool[i][1] = $urandom;
      end
      branch_pool[0] = 32'hFFFF_FFFC;
      branch_pool[1] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < ROW_COUNT; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_scheme(directed_rows[i].scheme);
         end else begin
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
            send_pair(directed_rows[i].cur, directed_rows[i].nxt, directed_rows[i].typed,
                      directed_rows[i].want);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         write_scheme((phase % 2 == 1) ? SCHEME_JUMP : SCHEME_PLAIN);
         throttle_on <= (phase != 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS - CALM_TAIL) throttle_on <= 1'b0;
            send_random_pair();
         end
      end

      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
src/btbp_pkg.sv
src/btbp_index.sv
src/branch_target_buffer_predictor_core.sv
test/tb_top.sv
